// ===== rtl/swrto_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the sliding-window sender engine.
// Used by every module under rtl; depends on nothing else.
package swrto_pkg;

   localparam int MAX_WINDOW_DEF = 64;

   localparam logic [31:0] RTO_RESET_US = 32'd1000000;
   localparam logic [31:0] MIN_DEV_US   = 32'd10000;

   localparam logic [6:0] WINDOW_RESET   = 7'd64;
   localparam logic [3:0] DUP_THR_RESET  = 4'd3;
   localparam logic [7:0] MAX_ATT_RESET  = 8'd50;

   typedef enum logic [2:0] {
      CMD_OPEN     = 3'd0,
      CMD_ENQUEUE  = 3'd1,
      CMD_TRANSMIT = 3'd2,
      CMD_ACK      = 3'd3,
      CMD_TIMEOUT  = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      ACT_NONE     = 3'd0,
      ACT_TRANSMIT = 3'd1,
      ACT_FAST     = 3'd2,
      ACT_TIMEOUT  = 3'd3,
      ACT_GIVE_UP  = 3'd4,
      ACT_DONE     = 3'd5
   } act_type;

   typedef struct packed {
      logic [6:0] window_size;
      logic [3:0] dup_ack_threshold;
      logic [7:0] max_attempts;
   } cfg_type;

   typedef struct packed {
      logic [31:0] srtt;
      logic [31:0] dev;
      logic [31:0] rto;
   } rtt_type;

   typedef struct packed {
      act_type     action;
      logic [31:0] tx_seq;
      logic [6:0]  credit_grant;
      logic [31:0] send_base;
      logic [31:0] rto_us;
      logic [6:0]  window_in_use;
      logic [31:0] timeout_resends;
      logic [31:0] fast_resends;
   } rsp_type;

endpackage

// ===== rtl/swrto_csr.sv =====
`timescale 1ns / 1ps
// Configuration registers behind the APB-style port.
// Depends on swrto_pkg for the cfg_type bundle and reset values.
module swrto_csr import swrto_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   localparam logic [1:0] REG_WINDOW  = 2'd0;
   localparam logic [1:0] REG_DUP_THR = 2'd1;
   localparam logic [1:0] REG_MAX_ATT = 2'd2;

   logic [6:0] window_ff;
   logic [3:0] dup_thr_ff;
   logic [7:0] max_att_ff;
   logic [1:0] reg_idx;
   logic       wr_en;

   assign reg_idx    = csr_paddr[3:2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff  <= WINDOW_RESET;
         dup_thr_ff <= DUP_THR_RESET;
         max_att_ff <= MAX_ATT_RESET;
      end else if (wr_en) begin
         case (reg_idx)
            REG_WINDOW:  window_ff  <= csr_pwdata[6:0];
            REG_DUP_THR: dup_thr_ff <= csr_pwdata[3:0];
            REG_MAX_ATT: max_att_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_WINDOW:  csr_prdata = {25'd0, window_ff};
         REG_DUP_THR: csr_prdata = {28'd0, dup_thr_ff};
         REG_MAX_ATT: csr_prdata = {24'd0, max_att_ff};
         default:     csr_prdata = 32'd0;
      endcase
   end

   assign cfg.window_size       = window_ff;
   assign cfg.dup_ack_threshold = dup_thr_ff;
   assign cfg.max_attempts      = max_att_ff;

endmodule

// ===== rtl/swrto_rtt.sv =====
`timescale 1ns / 1ps
// RTT estimator: smoothed RTT (gain 1/8), mean deviation (gain 1/4) and RTO.
// Pure shift-and-add datapath; depends on swrto_pkg for rtt_type and MIN_DEV_US.
module swrto_rtt import swrto_pkg::*; (
   input  logic [31:0] srtt,
   input  logic [31:0] dev,
   input  logic [31:0] sample,
   output rtt_type     est
);

   logic [34:0] srtt_acc;
   logic [31:0] srtt_new;
   logic [31:0] diff;
   logic [33:0] dev_acc;
   logic [31:0] dev_new;
   logic [31:0] dev_floor;
   logic [34:0] rto_acc;

   // 7*srtt + sample, then divide by 8
   assign srtt_acc  = {srtt, 3'b000} - {3'b000, srtt} + {3'b000, sample};
   assign srtt_new  = srtt_acc[34:3];
   assign diff      = (sample >= srtt_new) ? (sample - srtt_new) : (srtt_new - sample);
   assign dev_acc   = {1'b0, dev, 1'b0} + {2'b00, dev} + {2'b00, diff};
   assign dev_new   = dev_acc[33:2];
   assign dev_floor = (dev_new > MIN_DEV_US) ? dev_new : MIN_DEV_US;
   assign rto_acc   = {3'b000, srtt_new} + {1'b0, dev_floor, 2'b00};

   assign est.srtt = srtt_new;
   assign est.dev  = dev_new;
   assign est.rto  = (rto_acc[34:32] != 3'd0) ? 32'hFFFF_FFFF : rto_acc[31:0];

endmodule

// ===== rtl/swrto_core.sv =====
`timescale 1ns / 1ps
// Sender control core: input register, send-time stamp memory, window state
// and result register. Depends on swrto_pkg and swrto_rtt.
module swrto_core import swrto_pkg::*; #(
   parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [2:0]  in_command,
   input  logic [31:0] in_ack_seq,
   input  logic [15:0] in_peer_window,
   input  logic [31:0] in_time_us,
   input  logic [31:0] in_handshake_rtt_us,
   input  logic        in_finishing,
   output logic        out_valid,
   input  logic        out_ready,
   output rsp_type     out_rsp
);

   // The ring index is the low bits of the sequence number; live sequence
   // numbers always span at most MAX_WINDOW values, so they never collide.
   localparam int SLOT_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int SLOT_DEPTH = 2 ** SLOT_W;

   logic [31:0] stamp_mem [SLOT_DEPTH];
   logic [31:0] stamp_rd_ff;

   logic        pend_ff;
   logic [2:0]  cmd_ff;
   logic [31:0] ack_ff, time_ff, hrtt_ff;
   logic [15:0] peer_ff;
   logic        fin_ff;

   logic [31:0] base_ff, enq_ff, tx_ff, credit_ff;
   logic [31:0] srtt_ff, dev_ff, rto_ff, to_total_ff, fast_total_ff;
   logic [7:0]  dup_ff, base_att_ff;
   logic [6:0]  eff_ff;
   logic [31:0] base_in, enq_in, tx_in, credit_in;
   logic [31:0] srtt_in, dev_in, rto_in, to_total_in, fast_total_in;
   logic [7:0]  dup_in, base_att_in;
   logic [6:0]  eff_in;

   logic        rsp_valid_ff;
   act_type     act_ff, act_in;
   logic [31:0] txo_ff, txo_in;
   logic [6:0]  grant_ff, grant_in;

   logic              advance;
   logic              stamp_we;
   logic [SLOT_W-1:0] rd_addr;
   logic [6:0]        win;
   logic [6:0]        eff_peer;
   logic [31:0]       outstanding, avail, in_flight, pend, delta, credit_gap;
   logic [33:0]       hrtt3;
   logic [7:0]        base_att_inc, dup_inc;
   logic [31:0]       sample;
   rtt_type           est;

   swrto_rtt u_rtt (
      .srtt   (srtt_ff),
      .dev    (dev_ff),
      .sample (sample),
      .est    (est)
   );

   assign advance  = pend_ff & (~rsp_valid_ff | out_ready);
   assign in_ready = ~pend_ff | advance;
   assign rd_addr  = in_ack_seq[SLOT_W-1:0] - SLOT_W'(1);

   always_comb begin
      if (cfg.window_size == 7'd0) begin
         win = 7'd1;
      end else if ({25'd0, cfg.window_size} > 32'(MAX_WINDOW)) begin
         win = 7'(MAX_WINDOW);
      end else begin
         win = cfg.window_size;
      end
   end

   assign eff_peer     = (peer_ff < {9'd0, win}) ? peer_ff[6:0] : win;
   assign outstanding  = tx_ff - base_ff;
   assign avail        = credit_ff - enq_ff;
   assign in_flight    = enq_ff - base_ff;
   assign pend         = enq_ff - tx_ff;
   assign delta        = ack_ff - base_ff;
   assign credit_gap   = ack_ff + {25'd0, eff_peer} - credit_ff;
   assign hrtt3        = {2'b00, hrtt_ff} + {1'b0, hrtt_ff, 1'b0};
   assign base_att_inc = (base_att_ff == 8'hFF) ? base_att_ff : base_att_ff + 8'd1;
   assign dup_inc      = (dup_ff == 8'hFF) ? dup_ff : dup_ff + 8'd1;
   assign sample       = time_ff - stamp_rd_ff;

   always_comb begin
      base_in       = base_ff;
      enq_in        = enq_ff;
      tx_in         = tx_ff;
      credit_in     = credit_ff;
      srtt_in       = srtt_ff;
      dev_in        = dev_ff;
      rto_in        = rto_ff;
      to_total_in   = to_total_ff;
      fast_total_in = fast_total_ff;
      dup_in        = dup_ff;
      base_att_in   = base_att_ff;
      eff_in        = eff_ff;
      act_in        = ACT_NONE;
      txo_in        = 32'd0;
      grant_in      = 7'd0;
      stamp_we      = 1'b0;
      case (cmd_type'(cmd_ff))
         CMD_OPEN: begin
            base_in     = 32'd0;
            enq_in      = 32'd0;
            tx_in       = 32'd0;
            dup_in      = 8'd0;
            base_att_in = 8'd0;
            rto_in      = (hrtt3[33:32] != 2'd0) ? 32'hFFFF_FFFF : hrtt3[31:0];
            srtt_in     = rto_in;
            dev_in      = 32'd0;
            eff_in      = eff_peer;
            credit_in   = {25'd0, eff_peer};
            grant_in    = eff_peer;
         end
         CMD_ENQUEUE: begin
            if (avail != 32'd0 && avail <= 32'(MAX_WINDOW) && in_flight < {25'd0, win}) begin
               stamp_we = 1'b1;
               enq_in   = enq_ff + 32'd1;
               if (enq_ff == base_ff) begin
                  base_att_in = 8'd0;
               end
            end
         end
         CMD_TRANSMIT: begin
            if (pend != 32'd0 && pend <= {25'd0, win}) begin
               act_in = ACT_TRANSMIT;
               txo_in = tx_ff;
               tx_in  = tx_ff + 32'd1;
               if (tx_ff == base_ff) begin
                  base_att_in = base_att_inc;
               end
            end
         end
         CMD_ACK: begin
            if (delta != 32'd0 && delta <= outstanding) begin
               // Only the base can have been resent; every later packet went out once.
               if (base_att_ff == 8'd1) begin
                  srtt_in = est.srtt;
                  dev_in  = est.dev;
                  rto_in  = est.rto;
               end
               base_in     = ack_ff;
               base_att_in = (ack_ff != tx_ff) ? 8'd1 : 8'd0;
               dup_in      = 8'd0;
               eff_in      = eff_peer;
               if (credit_gap != 32'd0 && !credit_gap[31]) begin
                  grant_in  = (credit_gap > {25'd0, eff_peer}) ? eff_peer : credit_gap[6:0];
                  credit_in = credit_ff + {25'd0, grant_in};
               end
            end else if (delta == 32'd0 && outstanding != 32'd0) begin
               dup_in = dup_inc;
               if (dup_inc == {4'd0, cfg.dup_ack_threshold}) begin
                  act_in        = ACT_FAST;
                  txo_in        = base_ff;
                  base_att_in   = base_att_inc;
                  fast_total_in = fast_total_ff + 32'd1;
               end
            end
         end
         CMD_TIMEOUT: begin
            if (fin_ff && base_ff == enq_ff) begin
               act_in = ACT_DONE;
            end else if (outstanding != 32'd0) begin
               if (base_att_ff < cfg.max_attempts) begin
                  act_in      = ACT_TIMEOUT;
                  txo_in      = base_ff;
                  base_att_in = base_att_inc;
                  to_total_in = to_total_ff + 32'd1;
               end else begin
                  act_in = ACT_GIVE_UP;
               end
            end
         end
         default: ;
      endcase
   end

   // Stamp memory: written by enqueue, read for the ACK's last packet on accept
   always_ff @(posedge clock) begin
      if (advance && stamp_we) begin
         stamp_mem[enq_ff[SLOT_W-1:0]] <= time_ff;
      end
      if (in_valid && in_ready) begin
         stamp_rd_ff <= stamp_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         cmd_ff  <= in_command;
         ack_ff  <= in_ack_seq;
         peer_ff <= in_peer_window;
         time_ff <= in_time_us;
         hrtt_ff <= in_handshake_rtt_us;
         fin_ff  <= in_finishing;
      end
      if (advance) begin
         act_ff   <= act_in;
         txo_ff   <= txo_in;
         grant_ff <= grant_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         base_ff       <= 32'd0;
         enq_ff        <= 32'd0;
         tx_ff         <= 32'd0;
         credit_ff     <= 32'd0;
         srtt_ff       <= 32'd0;
         dev_ff        <= 32'd0;
         rto_ff        <= RTO_RESET_US;
         to_total_ff   <= 32'd0;
         fast_total_ff <= 32'd0;
         dup_ff        <= 8'd0;
         base_att_ff   <= 8'd0;
         eff_ff        <= 7'd0;
      end else begin
         if (in_ready) begin
            pend_ff <= in_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (out_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (advance) begin
            base_ff       <= base_in;
            enq_ff        <= enq_in;
            tx_ff         <= tx_in;
            credit_ff     <= credit_in;
            srtt_ff       <= srtt_in;
            dev_ff        <= dev_in;
            rto_ff        <= rto_in;
            to_total_ff   <= to_total_in;
            fast_total_ff <= fast_total_in;
            dup_ff        <= dup_in;
            base_att_ff   <= base_att_in;
            eff_ff        <= eff_in;
         end
      end
   end

   // State only moves when a new result loads, so it doubles as result payload
   assign out_valid               = rsp_valid_ff;
   assign out_rsp.action          = act_ff;
   assign out_rsp.tx_seq          = txo_ff;
   assign out_rsp.credit_grant    = grant_ff;
   assign out_rsp.send_base       = base_ff;
   assign out_rsp.rto_us          = rto_ff;
   assign out_rsp.window_in_use   = eff_ff;
   assign out_rsp.timeout_resends = to_total_ff;
   assign out_rsp.fast_resends    = fast_total_ff;

endmodule

// ===== rtl/sliding_window_ack_rto_engine.sv =====
`timescale 1ns / 1ps
// Sliding-window sender with ACK tracking, Jacobson RTO and fast retransmit.
// An accepted req beat passes the input register, then the result register.
// Throughput: one beat per cycle unless rsp backpressure stalls it, set by the
// single state-update pass. Reset (synchronous, high) clears all window state,
// sets RTO to 1 s, registers to defaults; the send-time stamp memory is not cleared.
module sliding_window_ack_rto_engine import swrto_pkg::*; #(
   parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [31:0] ack_seq, [47:32] peer_window, [79:48] time_us,
   // [111:80] handshake_rtt_us, [112] finishing, [119:113] zero
   input  logic [119:0] req_tdata,
   // [2:0] command
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [31:0] tx_seq, [38:32] credit_grant, [70:39] send_base, [102:71] rto_us,
   // [109:103] window_in_use, [141:110] timeout_resends, [173:142] fast_resends,
   // [175:174] zero
   output logic [175:0] rsp_tdata,
   // [2:0] action
   output logic [2:0]   rsp_tuser,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   cfg_type cfg;
   rsp_type rsp;

   swrto_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   swrto_core #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_core (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg),
      .in_valid            (req_tvalid),
      .in_ready            (req_tready),
      .in_command          (req_tuser),
      .in_ack_seq          (req_tdata[31:0]),
      .in_peer_window      (req_tdata[47:32]),
      .in_time_us          (req_tdata[79:48]),
      .in_handshake_rtt_us (req_tdata[111:80]),
      .in_finishing        (req_tdata[112]),
      .out_valid           (rsp_tvalid),
      .out_ready           (rsp_tready),
      .out_rsp             (rsp)
   );

   assign rsp_tuser = rsp.action;
   assign rsp_tdata = {2'b00, rsp.fast_resends, rsp.timeout_resends, rsp.window_in_use,
                       rsp.rto_us, rsp.send_base, rsp.credit_grant, rsp.tx_seq};

`ifndef SYNTHESIS
   a_grant_in_window: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp.credit_grant <= rsp.window_in_use)
      else $error("credit grant exceeds effective window");

   a_tx_only_on_send: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp.action == ACT_NONE || rsp.action == ACT_GIVE_UP ||
                     rsp.action == ACT_DONE) |-> rsp.tx_seq == 32'd0)
      else $error("tx_seq set on a beat that sends nothing");

   a_stall_needs_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without result backpressure");
`endif

endmodule
